// ----- rtl/core/tcab_pkg.sv -----
// ---------------------------------------------------------------------------
// tcab_pkg
// Shared types and constants of the tiny CPU ALU/branch core: sizes, item
// commands, instruction field codes and the structs passed between parts.
// ---------------------------------------------------------------------------
package tcab_pkg;

	localparam int STORE_WORDS = 256;
	localparam int REG_COUNT   = 8;
	localparam int STORE_AW    = $clog2(STORE_WORDS);
	localparam int REG_AW      = $clog2(REG_COUNT);

	// queue depths, powers of two
	localparam int FQ_DEPTH    = 2;
	localparam int RESQ_DEPTH  = 4;
	localparam int RESQ_AW     = $clog2(RESQ_DEPTH);
	localparam int RESQ_CW     = $clog2(RESQ_DEPTH + 1);

	typedef enum logic [1:0] {
		CMD_LOAD = 2'd0,
		CMD_STEP = 2'd1,
		CMD_READ = 2'd2,
		CMD_NOP  = 2'd3
	} cmd_t;

	// low two bits of an instruction word
	localparam logic [1:0] FMT_IMM    = 2'b01;
	localparam logic [1:0] FMT_BRANCH = 2'b10;

	// branch condition that never jumps
	localparam logic [1:0] COND_NEVER = 2'b11;

	typedef enum logic [2:0] {
		OP_ADD = 3'd0,
		OP_SUB = 3'd1,
		OP_AND = 3'd2,
		OP_OR  = 3'd3,
		OP_XOR = 3'd4,
		OP_SHL = 3'd5,
		OP_SHR = 3'd6,
		OP_CMP = 3'd7
	} alu_op_t;

	localparam logic [15:0] CMP_EQ = 16'd0;
	localparam logic [15:0] CMP_GT = 16'd1;
	localparam logic [15:0] CMP_LT = 16'd2;

	typedef struct packed {
		cmd_t        cmd;
		logic        load_en;
		logic [7:0]  store_address;
		logic [15:0] store_word;
		logic [2:0]  reg_index;
	} item_t;

	typedef struct packed {
		logic [15:0] value;
		logic [15:0] executed_word;
		logic [7:0]  next_pc;
		logic        was_branch;
		logic        branch_taken;
	} result_t;

endpackage

// ----- rtl/core/tcab_ram.sv -----
// ---------------------------------------------------------------------------
// tcab_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module tcab_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// read returns the old contents on a same-address write
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/core/tcab_front.sv -----
// ---------------------------------------------------------------------------
// tcab_front
// Input side: takes item beats, classifies them into commands and holds
// them in a short queue for the execution side.
// ---------------------------------------------------------------------------
module tcab_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	output logic            full,
	input  logic [1:0]      kind,
	input  logic [7:0]      store_address,
	input  logic [15:0]     store_word,
	input  logic [2:0]      reg_index,
	output logic            fq_valid,
	output tcab_pkg::item_t fq_item,
	input  logic            fq_pop
);
	import tcab_pkg::*;

	localparam int FQ_AW = $clog2(FQ_DEPTH);
	localparam int FQ_CW = $clog2(FQ_DEPTH + 1);

	item_t            mem_q [FQ_DEPTH];
	logic [FQ_AW-1:0] wr_ptr_q;
	logic [FQ_AW-1:0] rd_ptr_q;
	logic [FQ_CW-1:0] cnt_q;
	item_t            cls;
	logic             do_push;
	logic             do_pop;

	always_comb begin
		cls.cmd           = cmd_t'(kind);
		// loads beyond the store are dropped
		cls.load_en       = (cmd_t'(kind) == CMD_LOAD) &&
		                    ({1'b0, store_address} < 9'(STORE_WORDS));
		cls.store_address = store_address;
		cls.store_word    = store_word;
		cls.reg_index     = reg_index;
	end

	assign full     = (cnt_q == FQ_CW'(FQ_DEPTH));
	assign fq_valid = (cnt_q != '0);
	assign fq_item  = mem_q[rd_ptr_q];
	assign do_push  = push && !full;
	assign do_pop   = fq_pop && fq_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ----- rtl/core/tcab_back.sv -----
// ---------------------------------------------------------------------------
// tcab_back
// Execution side: instruction store, register file, program counter and
// ALU. Dispatch fetches, s1 decodes and resolves branches, s2 runs the ALU
// and writes back.
// ---------------------------------------------------------------------------
module tcab_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          fq_valid,
	input  tcab_pkg::item_t               fq_item,
	output logic                          fq_pop,
	input  logic [tcab_pkg::RESQ_CW-1:0]  res_count,
	output logic [1:0]                    inflight,
	output logic                          res_push,
	output tcab_pkg::result_t             res_data
);
	import tcab_pkg::*;

	// program state
	logic [7:0]             pc_q;
	logic [15:0]            last_result_q;
	logic [STORE_WORDS-1:0] st_vld_q;
	logic [REG_COUNT-1:0]   rf_vld_q;

	// dispatch
	logic dispatch;
	logic credit_ok;
	logic pc_in_range;

	// s1
	logic  v_s1;
	cmd_t  cmd_s1;
	logic  fetch_ok_s1;
	logic  s1_step;
	logic  s1_alu;
	logic  s1_branch;
	logic [15:0] w_s1;
	logic [1:0]  cond;
	logic        taken;
	logic [7:0]  pc_inc;
	logic [7:0]  pc_nxt;

	// s2
	logic        v_s2;
	logic [15:0] word_s2;

	// memories
	logic              st_we;
	logic              st_re;
	logic [15:0]       st_rdata;
	logic              st_vld_rd_q;
	logic              rf_we;
	logic [REG_AW-1:0] rf_waddr;
	logic              rf_re_a;
	logic              rf_re_b;
	logic [REG_AW-1:0] rf_addr_a;
	logic [REG_AW-1:0] rf_addr_b;
	logic [15:0]       rf_rdata_a;
	logic [15:0]       rf_rdata_b;
	logic              a_vld_q;
	logic              b_vld_q;
	logic              a_hit_q;
	logic              b_hit_q;
	logic [15:0]       byp_q;
	logic [15:0]       rd_a;
	logic [15:0]       rd_b;

	// ALU
	logic [15:0] opb;
	logic [15:0] alu_r;

	// -----------------------------------------------------------------------
	// dispatch: a step holds off the next item until its PC update is known
	// -----------------------------------------------------------------------
	assign inflight    = {1'b0, v_s1} + {1'b0, v_s2};
	assign credit_ok   = ((RESQ_CW+1)'(res_count) + (RESQ_CW+1)'(inflight)) <
	                     (RESQ_CW+1)'(RESQ_DEPTH);
	assign s1_step     = v_s1 && (cmd_s1 == CMD_STEP);
	assign dispatch    = fq_valid && !s1_step && credit_ok;
	assign fq_pop      = dispatch;
	assign pc_in_range = ({1'b0, pc_q} < 9'(STORE_WORDS));

	assign st_we = dispatch && fq_item.load_en;
	assign st_re = dispatch && (fq_item.cmd == CMD_STEP) && pc_in_range;

	tcab_ram #(
		.WIDTH(16),
		.DEPTH(STORE_WORDS)
	) u_store (
		.clk  (clk),
		.we   (st_we),
		.waddr(fq_item.store_address[STORE_AW-1:0]),
		.wdata(fq_item.store_word),
		.re   (st_re),
		.raddr(pc_q[STORE_AW-1:0]),
		.rdata(st_rdata)
	);

	// -----------------------------------------------------------------------
	// s1: decode fetched word
	// -----------------------------------------------------------------------
	// unwritten or out-of-range words fetch as zero
	assign w_s1      = (fetch_ok_s1 && st_vld_rd_q) ? st_rdata : '0;
	assign s1_alu    = s1_step && (w_s1[1:0] != FMT_BRANCH);
	assign s1_branch = s1_step && (w_s1[1:0] == FMT_BRANCH);
	assign cond      = w_s1[3:2];
	assign taken     = (cond != COND_NEVER) && (last_result_q == {14'd0, cond});
	assign pc_inc    = pc_q + 8'd1;
	assign pc_nxt    = (s1_branch && taken) ? w_s1[11:4] : pc_inc;

	// register file, duplicated for two read ports
	assign rf_we     = v_s2;
	assign rf_waddr  = word_s2[15:13];
	assign rf_re_a   = s1_alu || (dispatch && (fq_item.cmd == CMD_READ));
	assign rf_addr_a = s1_alu ? w_s1[15:13] : fq_item.reg_index;
	assign rf_re_b   = s1_alu;
	assign rf_addr_b = w_s1[12:10];

	tcab_ram #(
		.WIDTH(16),
		.DEPTH(REG_COUNT)
	) u_rf_a (
		.clk  (clk),
		.we   (rf_we),
		.waddr(rf_waddr),
		.wdata(alu_r),
		.re   (rf_re_a),
		.raddr(rf_addr_a),
		.rdata(rf_rdata_a)
	);

	tcab_ram #(
		.WIDTH(16),
		.DEPTH(REG_COUNT)
	) u_rf_b (
		.clk  (clk),
		.we   (rf_we),
		.waddr(rf_waddr),
		.wdata(alu_r),
		.re   (rf_re_b),
		.raddr(rf_addr_b),
		.rdata(rf_rdata_b)
	);

	// forward a same-cycle write-back; unwritten registers read zero
	assign rd_a = a_hit_q ? byp_q : (a_vld_q ? rf_rdata_a : '0);
	assign rd_b = b_hit_q ? byp_q : (b_vld_q ? rf_rdata_b : '0);

	// -----------------------------------------------------------------------
	// s2: ALU and write-back
	// -----------------------------------------------------------------------
	assign opb = (word_s2[1:0] == FMT_IMM) ? {8'd0, word_s2[12:5]} : rd_b;

	always_comb begin
		case (alu_op_t'(word_s2[4:2]))
			OP_ADD:  alu_r = rd_a + opb;
			OP_SUB:  alu_r = rd_a - opb;
			OP_AND:  alu_r = rd_a & opb;
			OP_OR:   alu_r = rd_a | opb;
			OP_XOR:  alu_r = rd_a ^ opb;
			OP_SHL:  alu_r = rd_a << opb[3:0];
			OP_SHR:  alu_r = rd_a >> opb[3:0];
			OP_CMP:  alu_r = (rd_a == opb) ? CMP_EQ : ((rd_a > opb) ? CMP_GT : CMP_LT);
			default: alu_r = '0;
		endcase
	end

	// -----------------------------------------------------------------------
	// result beat: s2 and a finishing s1 never coincide
	// -----------------------------------------------------------------------
	assign res_push = v_s2 || (v_s1 && !s1_alu);

	always_comb begin
		res_data = '0;
		res_data.next_pc = pc_q;
		if (v_s2) begin
			res_data.value         = alu_r;
			res_data.executed_word = word_s2;
		end else if (s1_branch) begin
			res_data.executed_word = w_s1;
			res_data.next_pc       = pc_nxt;
			res_data.was_branch    = 1'b1;
			res_data.branch_taken  = taken;
		end else if (cmd_s1 == CMD_READ) begin
			res_data.value = rd_a;
		end
	end

	// -----------------------------------------------------------------------
	// registers
	// -----------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1          <= 1'b0;
			v_s2          <= 1'b0;
			pc_q          <= '0;
			last_result_q <= '0;
			st_vld_q      <= '0;
			rf_vld_q      <= '0;
		end else begin
			v_s1 <= dispatch;
			v_s2 <= s1_alu;
			if (s1_step) begin
				pc_q <= pc_nxt;
			end
			if (v_s2) begin
				last_result_q <= alu_r;
			end
			if (st_we) begin
				st_vld_q[fq_item.store_address[STORE_AW-1:0]] <= 1'b1;
			end
			if (rf_we) begin
				rf_vld_q[rf_waddr] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (dispatch) begin
			cmd_s1      <= fq_item.cmd;
			fetch_ok_s1 <= pc_in_range;
		end
		if (st_re) begin
			st_vld_rd_q <= st_vld_q[pc_q[STORE_AW-1:0]];
		end
		if (s1_alu) begin
			word_s2 <= w_s1;
		end
		if (rf_we) begin
			byp_q <= alu_r;
		end
		if (rf_re_a) begin
			a_vld_q <= rf_vld_q[rf_addr_a];
			a_hit_q <= rf_we && (rf_waddr == rf_addr_a);
		end
		if (rf_re_b) begin
			b_vld_q <= rf_vld_q[rf_addr_b];
			b_hit_q <= rf_we && (rf_waddr == rf_addr_b);
		end
	end

endmodule

// ----- rtl/core/tcab_resq.sv -----
// ---------------------------------------------------------------------------
// tcab_resq
// Result queue: holds finished result beats until the consumer pops them.
// ---------------------------------------------------------------------------
module tcab_resq (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         res_push,
	input  tcab_pkg::result_t            res_data,
	output logic [tcab_pkg::RESQ_CW-1:0] res_count,
	output logic                         empty,
	input  logic                         pop,
	output tcab_pkg::result_t            head
);
	import tcab_pkg::*;

	result_t            mem_q [RESQ_DEPTH];
	logic [RESQ_AW-1:0] wr_ptr_q;
	logic [RESQ_AW-1:0] rd_ptr_q;
	logic [RESQ_CW-1:0] cnt_q;
	logic               do_pop;

	assign empty     = (cnt_q == '0);
	assign head      = mem_q[rd_ptr_q];
	assign res_count = cnt_q;
	assign do_pop    = pop && !empty;

	// the execution side reserves a slot before dispatch, so push never overflows
	always_ff @(posedge clk) begin
		if (res_push) begin
			mem_q[wr_ptr_q] <= res_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (res_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({res_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ----- rtl/core/tiny_cpu_alu_branch_core.sv -----
// ---------------------------------------------------------------------------
// tiny_cpu_alu_branch_core
// Small 16-bit processor core with queue-style item and result ports.
// ---------------------------------------------------------------------------
// Every accepted item gives exactly one result beat, in order. Load, read
// and unused-kind items can be dispatched back to back; a step holds off
// the next item until it is decoded in s1, where an ALU step reads the
// register file, and its ALU write-back overlaps the next item. A result
// beat passes through the input queue, s1 and the result queue, and also
// s2 for an ALU step. A two-entry input queue and a four-entry result queue
// let each side stall independently. Store and register contents are
// tracked by per-entry valid bits, so there is no clearing pass after
// reset: items are taken straight after reset.
module tiny_cpu_alu_branch_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  kind,
	input  logic [7:0]  store_address,
	input  logic [15:0] store_word,
	input  logic [2:0]  reg_index,
	output logic        empty,
	input  logic        pop,
	output logic [15:0] value,
	output logic [15:0] executed_word,
	output logic [7:0]  next_pc,
	output logic        was_branch,
	output logic        branch_taken
);
	import tcab_pkg::*;

	logic               fq_valid;
	item_t              fq_item;
	logic               fq_pop;
	logic [RESQ_CW-1:0] res_count;
	logic [1:0]         inflight;
	logic               res_push;
	result_t            res_data;
	result_t            head;

	tcab_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.kind         (kind),
		.store_address(store_address),
		.store_word   (store_word),
		.reg_index    (reg_index),
		.fq_valid     (fq_valid),
		.fq_item      (fq_item),
		.fq_pop       (fq_pop)
	);

	tcab_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.fq_valid (fq_valid),
		.fq_item  (fq_item),
		.fq_pop   (fq_pop),
		.res_count(res_count),
		.inflight (inflight),
		.res_push (res_push),
		.res_data (res_data)
	);

	tcab_resq u_resq (
		.clk      (clk),
		.arst_n   (arst_n),
		.res_push (res_push),
		.res_data (res_data),
		.res_count(res_count),
		.empty    (empty),
		.pop      (pop),
		.head     (head)
	);

	assign value         = head.value;
	assign executed_word = head.executed_word;
	assign next_pc       = head.next_pc;
	assign was_branch    = head.was_branch;
	assign branch_taken  = head.branch_taken;

`ifndef SYNTH
	a_resq_credit: assert property (@(posedge clk) disable iff (!arst_n)
		(int'(res_count) + int'(inflight)) <= RESQ_DEPTH)
		else $error("result queue credit exceeded");

	a_resq_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> (res_count != RESQ_CW'(RESQ_DEPTH)))
		else $error("result beat pushed into a full queue");

	a_fq_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		fq_pop |-> fq_valid)
		else $error("item queue popped while empty");

	a_step_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(fq_pop && (fq_item.cmd == CMD_STEP)) |=> !fq_pop)
		else $error("item dispatched behind an unresolved step");
`endif

endmodule

// ----- bench/tb_top.sv -----
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for tiny_cpu_alu_branch_core. A shadow copy of the
// register file, instruction store, counter and last ALU result predicts one
// result beat per accepted item. Actual beats are compared field by field in
// order. A short directed program is followed by randomized load, step, read
// and unused-kind traffic, with random idling on both the push and pop sides.
// ---------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import tcab_pkg::*;

	localparam int RANDOM_ITEMS = 1030;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int IDLE_PCT     = 29;

	class cpu_shadow;
		logic [15:0] regs [REG_COUNT];
		logic [15:0] store [STORE_WORDS];
		logic [7:0]  pc;
		logic [15:0] last_res;
		result_t     pending [$];
		int          mismatches;

		function new();
			foreach (regs[i]) regs[i] = '0;
			foreach (store[i]) store[i] = '0;
			pc = '0;
			last_res = '0;
			mismatches = 0;
		endfunction

		// predict the beat for one accepted item and update the shadow state
		function void note_item(cmd_t k, logic [7:0] addr, logic [15:0] word,
		                        logic [2:0] idx);
			result_t     exp;
			logic [15:0] w, a, b, r;
			logic [2:0]  dst;
			exp = '0;
			case (k)
				CMD_LOAD: begin
					if (int'(addr) < STORE_WORDS)
						store[addr] = word;
				end
				CMD_STEP: begin
					w = (int'(pc) < STORE_WORDS) ? store[pc] : 16'h0000;
					exp.executed_word = w;
					if (w[1:0] == FMT_BRANCH) begin
						exp.was_branch = 1'b1;
						pc = pc + 8'd1;
						if (w[3:2] != COND_NEVER && last_res == {14'd0, w[3:2]}) begin
							pc = w[11:4];
							exp.branch_taken = 1'b1;
						end
					end else begin
						dst = w[15:13];
						a = regs[dst];
						b = (w[1:0] == FMT_IMM) ? {8'd0, w[12:5]} : regs[w[12:10]];
						case (alu_op_t'(w[4:2]))
							OP_ADD: r = a + b;
							OP_SUB: r = a - b;
							OP_AND: r = a & b;
							OP_OR:  r = a | b;
							OP_XOR: r = a ^ b;
							OP_SHL: r = a << b[3:0];
							OP_SHR: r = a >> b[3:0];
							default: r = (a == b) ? CMP_EQ : ((a > b) ? CMP_GT : CMP_LT);
						endcase
						regs[dst] = r;
						last_res = r;
						exp.value = r;
						pc = pc + 8'd1;
					end
				end
				CMD_READ: exp.value = regs[idx];
				default: ;
			endcase
			exp.next_pc = pc;
			pending.push_back(exp);
		endfunction

		function void check_beat(result_t got);
			result_t exp;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: result beat with nothing expected: %p", $realtime, got);
				return;
			end
			exp = pending.pop_front();
			if (got.value !== exp.value || got.executed_word !== exp.executed_word ||
			    got.next_pc !== exp.next_pc || got.was_branch !== exp.was_branch ||
			    got.branch_taken !== exp.branch_taken) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: mismatch value %h/%h word %h/%h pc %h/%h br %b/%b taken %b/%b",
					         $realtime, exp.value, got.value, exp.executed_word,
					         got.executed_word, exp.next_pc, got.next_pc, exp.was_branch,
					         got.was_branch, exp.branch_taken, got.branch_taken);
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        full;
	logic [1:0]  kind = CMD_NOP;
	logic [7:0]  store_address = '0;
	logic [15:0] store_word = '0;
	logic [2:0]  reg_index = '0;
	logic        empty;
	logic        pop = 1'b0;
	logic [15:0] value;
	logic [15:0] executed_word;
	logic [7:0]  next_pc;
	logic        was_branch;
	logic        branch_taken;

	cpu_shadow board;
	bit        steady = 1'b0;
	int        cycles = 0;

	tiny_cpu_alu_branch_core i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.kind          (kind),
		.store_address (store_address),
		.store_word    (store_word),
		.reg_index     (reg_index),
		.empty         (empty),
		.pop           (pop),
		.value         (value),
		.executed_word (executed_word),
		.next_pc       (next_pc),
		.was_branch    (was_branch),
		.branch_taken  (branch_taken)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// result side: pop decided on the falling edge, beat taken on the rising edge
	always @(negedge clk)
		pop <= steady || ($urandom_range(0, 99) >= IDLE_PCT);

	always @(posedge clk)
		if (arst_n && pop && !empty)
			board.check_beat(result_t'({value, executed_word, next_pc, was_branch,
			                            branch_taken}));

	function automatic logic [15:0] alu_reg(logic [2:0] dst, logic [2:0] src, alu_op_t op);
		return {dst, src, 5'd0, op, 2'b00};
	endfunction

	function automatic logic [15:0] alu_imm(logic [2:0] dst, logic [7:0] imm, alu_op_t op);
		return {dst, imm, op, FMT_IMM};
	endfunction

	function automatic logic [15:0] branch_word(logic [3:0] top, logic [7:0] target,
	                                            logic [1:0] cond);
		return {top, target, cond, FMT_BRANCH};
	endfunction

	// program words: branches and compares are weighted up so that jumps get taken
	function automatic logic [15:0] program_word();
		int          pick;
		logic [15:0] w;
		logic [7:0]  target;
		pick = $urandom_range(0, 99);
		w = 16'($urandom);
		if (pick < 25) begin
			target = ($urandom_range(0, 1) == 1) ? 8'($urandom) :
			         board.pc + 8'($urandom_range(0, 12));
			return branch_word(w[15:12], target, 2'($urandom_range(0, 3)));
		end
		if (pick < 50)
			w[4:2] = OP_CMP;
		return w;
	endfunction

	task automatic send_item(cmd_t k, logic [7:0] addr, logic [15:0] word, logic [2:0] idx);
		@(negedge clk);
		while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push <= 1'b1;
		kind <= k;
		store_address <= addr;
		store_word <= word;
		reg_index <= idx;
		@(posedge clk);
		while (full)
			@(posedge clk);
		board.note_item(k, addr, word, idx);
	endtask

	// hold off the sender until every expected beat has come back
	task automatic drain_results();
		@(negedge clk);
		push <= 1'b0;
		while (board.pending.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		int          pick;
		cmd_t        k;
		logic [7:0]  addr;
		logic [15:0] word;
		board = new();
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;

		// directed: small program that touches each operation group, a taken
		// branch to the top of the store, and the counter wrapping to zero
		send_item(CMD_LOAD, 8'd0, alu_imm(3'd1, 8'hFF, OP_ADD), 3'd0);
		send_item(CMD_LOAD, 8'd1, alu_reg(3'd2, 3'd1, OP_SUB), 3'd0);
		send_item(CMD_LOAD, 8'd2, alu_reg(3'd2, 3'd1, OP_SHL), 3'd0);
		send_item(CMD_LOAD, 8'd3, alu_imm(3'd2, 8'd15, OP_SHR), 3'd0);
		send_item(CMD_LOAD, 8'd4, branch_word(4'd0, 8'hFE, 2'd1), 3'd0);
		send_item(CMD_LOAD, 8'hFE, alu_reg(3'd3, 3'd1, OP_XOR), 3'd0);
		send_item(CMD_LOAD, 8'hFF, alu_imm(3'd3, 8'hFF, OP_CMP), 3'd0);
		send_item(CMD_LOAD, 8'd200, 16'hFFFF, 3'd0);
		repeat (8)
			send_item(CMD_STEP, 8'd0, 16'd0, 3'd0);
		send_item(CMD_READ, 8'd0, 16'd0, 3'd7);
		send_item(CMD_READ, 8'd0, 16'd0, 3'd3);
		send_item(CMD_READ, 8'd0, 16'd0, 3'd2);
		send_item(CMD_NOP, 8'hFF, 16'hFFFF, 3'd7);
		drain_results();

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			steady = (i >= 200 && i < 450);
			if (i == 600)
				drain_results();
			pick = $urandom_range(0, 99);
			addr = 8'($urandom);
			word = 16'($urandom);
			if (pick < 35) begin
				k = CMD_LOAD;
				if ($urandom_range(0, 9) < 6)
					addr = board.pc + 8'($urandom_range(0, 7));
				word = program_word();
			end else if (pick < 80) begin
				k = CMD_STEP;
			end else if (pick < 95) begin
				k = CMD_READ;
			end else begin
				k = CMD_NOP;
			end
			send_item(k, addr, word, 3'($urandom));
		end
		steady = 1'b0;
		drain_results();
		repeat (20) @(posedge clk);

		if (board.mismatches == 0 && board.pending.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// ----- files.f -----
rtl/core/tcab_pkg.sv
rtl/core/tcab_ram.sv
rtl/core/tcab_front.sv
rtl/core/tcab_back.sv
rtl/core/tcab_resq.sv
rtl/core/tiny_cpu_alu_branch_core.sv
bench/tb_top.sv
